### rtl/crcb_pkg.sv
// Shared types and constants for the bit-serial CRC codec.
// No dependencies; imported by every module of the block.
package crcb_pkg;

	// Largest generator degree supported by default
	localparam int MAX_DEGREE_DEF = 32;

	// Configuration register indexes
	localparam logic [1:0] REG_POLY_LOW   = 2'd0;
	localparam logic [1:0] REG_POLY_DEG   = 2'd1;
	localparam logic [1:0] REG_CHECK_MODE = 2'd2;

	// Reset values of the configuration registers
	localparam logic [31:0] POLY_LOW_RST = 32'h0000_1021;
	localparam logic [5:0]  POLY_DEG_RST = 6'd16;

	// Job kinds handed from the divider to the serialiser
	localparam logic [1:0] JOB_PASS  = 2'd0;  // encode, plain data bit
	localparam logic [1:0] JOB_TAIL  = 2'd1;  // encode, last data bit then check bits
	localparam logic [1:0] JOB_CHECK = 2'd2;  // check mode verdict

	typedef struct packed {
		logic [1:0] kind;
		logic       data_bit;
		logic       ok;
		logic       inv;
	} job_ctrl_t;

endpackage

### rtl/crcb_front.sv
// Front end: configuration registers and the GF(2) remainder divider.
// Depends on crcb_pkg; produces jobs for crcb_jobq.
module crcb_front #(
	parameter int MAX_DEGREE = crcb_pkg::MAX_DEGREE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_idx,
	input  logic [31:0]                        cfg_wdata,
	input  logic                               push,
	input  logic                               in_bit,
	input  logic                               in_last,
	input  logic                               q_full,
	output logic                               q_push,
	output crcb_pkg::job_ctrl_t                q_ctrl,
	output logic [MAX_DEGREE-1:0]              q_rem,
	output logic [$clog2(MAX_DEGREE+1)-1:0]    q_deg
);
	import crcb_pkg::*;

	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

	logic [31:0]           poly_low_q;
	logic [5:0]            poly_deg_q;
	logic                  check_mode_q;
	logic [MAX_DEGREE-1:0] remainder_q;

	logic [DW-1:0]         eff_d;
	logic [MAX_DEGREE-1:0] mask;
	logic [MAX_DEGREE-1:0] gen;
	logic [MAX_DEGREE-1:0] rem_cur;
	logic [MAX_DEGREE-1:0] rem_next;
	logic [63:0]           poly_wide;
	logic                  top;
	logic                  accept;

	// Clamp the programmed degree into 1..MAX_DEGREE
	always_comb begin
		priority if (poly_deg_q == 6'd0) begin
			eff_d = DW'(1);
		end else if ({1'b0, poly_deg_q} > 7'(MAX_DEGREE)) begin
			eff_d = DW'(MAX_DEGREE);
		end else begin
			eff_d = DW'(poly_deg_q);
		end
	end

	// Build the degree mask
	always_comb begin
		for (int k = 0; k < MAX_DEGREE; k++) begin
			mask[k] = (DW'(k) < eff_d);
		end
	end

	assign poly_wide = {32'd0, poly_low_q};
	assign gen       = poly_wide[MAX_DEGREE-1:0] & mask;
	assign rem_cur   = remainder_q & mask;
	assign top       = rem_cur[IW'(eff_d - DW'(1))];

	// One shift-and-XOR step of the long division
	always_comb begin
		if (check_mode_q) begin
			rem_next = ((rem_cur << 1) | MAX_DEGREE'(in_bit)) & mask;
			if (top) begin
				rem_next = rem_next ^ gen;
			end
		end else begin
			rem_next = (rem_cur << 1) & mask;
			if (top ^ in_bit) begin
				rem_next = rem_next ^ gen;
			end
		end
	end

	assign accept = push & ~q_full;

	// Queue a job for every beat that yields results
	assign q_push = accept & (~check_mode_q | in_last);
	always_comb begin
		q_ctrl.inv      = ~poly_low_q[0];
		q_ctrl.ok       = check_mode_q & (rem_next == '0);
		q_ctrl.data_bit = check_mode_q ? 1'b0 : in_bit;
		priority if (check_mode_q) begin
			q_ctrl.kind = JOB_CHECK;
		end else if (in_last) begin
			q_ctrl.kind = JOB_TAIL;
		end else begin
			q_ctrl.kind = JOB_PASS;
		end
	end
	assign q_rem = rem_next;
	assign q_deg = eff_d;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_low_q   <= POLY_LOW_RST;
			poly_deg_q   <= POLY_DEG_RST;
			check_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_POLY_LOW:   poly_low_q   <= cfg_wdata;
				REG_POLY_DEG:   poly_deg_q   <= cfg_wdata[5:0];
				REG_CHECK_MODE: check_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Advance the remainder; drop it at the end of each frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remainder_q <= '0;
		end else if (accept) begin
			remainder_q <= in_last ? '0 : rem_next;
		end
	end

endmodule

### rtl/crcb_jobq.sv
// Two-entry job queue between the divider and the serialiser.
// Depends on crcb_pkg for the job control struct.
module crcb_jobq #(
	parameter int MAX_DEGREE = crcb_pkg::MAX_DEGREE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr,
	input  crcb_pkg::job_ctrl_t             wr_ctrl,
	input  logic [MAX_DEGREE-1:0]           wr_rem,
	input  logic [$clog2(MAX_DEGREE+1)-1:0] wr_deg,
	output logic                            full,
	input  logic                            rd,
	output logic                            q_empty,
	output crcb_pkg::job_ctrl_t             rd_ctrl,
	output logic [MAX_DEGREE-1:0]           rd_rem,
	output logic [$clog2(MAX_DEGREE+1)-1:0] rd_deg
);
	import crcb_pkg::*;

	localparam int DW = $clog2(MAX_DEGREE + 1);

	job_ctrl_t             ctrl_q [2];
	logic [MAX_DEGREE-1:0] rem_q  [2];
	logic [DW-1:0]         deg_q  [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            cnt_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full    = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign do_wr   = wr & ~full;
	assign do_rd   = rd & ~q_empty;

	assign rd_ctrl = ctrl_q[rd_ptr_q];
	assign rd_rem  = rem_q[rd_ptr_q];
	assign rd_deg  = deg_q[rd_ptr_q];

	// Store the incoming job
	always_ff @(posedge clk) begin
		if (do_wr) begin
			ctrl_q[wr_ptr_q] <= wr_ctrl;
			rem_q[wr_ptr_q]  <= wr_rem;
			deg_q[wr_ptr_q]  <= wr_deg;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/crcb_back.sv
// Back end: expands jobs into result beats and holds the output register.
// Depends on crcb_pkg; reads jobs from crcb_jobq.
module crcb_back #(
	parameter int MAX_DEGREE = crcb_pkg::MAX_DEGREE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_empty,
	input  crcb_pkg::job_ctrl_t             q_ctrl,
	input  logic [MAX_DEGREE-1:0]           q_rem,
	input  logic [$clog2(MAX_DEGREE+1)-1:0] q_deg,
	output logic                            q_pop,
	output logic                            empty,
	input  logic                            pop,
	output logic                            out_bit,
	output logic                            out_last,
	output logic                            check_ok,
	output logic                            poly_invalid
);
	import crcb_pkg::*;

	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

	logic                  out_valid_q;
	logic                  out_bit_q;
	logic                  out_last_q;
	logic                  check_ok_q;
	logic                  poly_inv_q;
	logic [DW-1:0]         tail_cnt_q;
	logic [MAX_DEGREE-1:0] tail_rem_q;
	logic                  tail_inv_q;
	logic                  out_adv;
	logic                  in_tail;
	logic                  tail_bit;

	assign out_adv  = ~out_valid_q | pop;
	assign in_tail  = (tail_cnt_q != '0);
	assign q_pop    = out_adv & ~in_tail & ~q_empty;
	assign tail_bit = ~tail_inv_q & tail_rem_q[IW'(tail_cnt_q - DW'(1))];

	assign empty        = ~out_valid_q;
	assign out_bit      = out_bit_q;
	assign out_last     = out_last_q;
	assign check_ok     = check_ok_q;
	assign poly_invalid = poly_inv_q;

	// Output register payload: check bits first, else the next job
	always_ff @(posedge clk) begin
		if (out_adv) begin
			if (in_tail) begin
				out_bit_q  <= tail_bit;
				out_last_q <= (tail_cnt_q == DW'(1));
				check_ok_q <= 1'b0;
				poly_inv_q <= tail_inv_q;
			end else if (!q_empty) begin
				out_bit_q  <= q_ctrl.data_bit;
				out_last_q <= (q_ctrl.kind == JOB_CHECK);
				check_ok_q <= q_ctrl.ok;
				poly_inv_q <= q_ctrl.inv;
			end
		end
	end

	// Capture the remainder of a frame end for serialising
	always_ff @(posedge clk) begin
		if (q_pop && q_ctrl.kind == JOB_TAIL) begin
			tail_rem_q <= q_rem;
			tail_inv_q <= q_ctrl.inv;
		end
	end

	// Hold the beat while stalled, count down the check bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			tail_cnt_q  <= '0;
		end else if (out_adv) begin
			if (in_tail) begin
				out_valid_q <= 1'b1;
				tail_cnt_q  <= tail_cnt_q - DW'(1);
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				tail_cnt_q  <= (q_ctrl.kind == JOB_TAIL) ? q_deg : '0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/crc_bit_serial_codec.sv
// Top level of the bit-serial CRC codec with programmable generator.
// Depends on crcb_pkg, crcb_front, crcb_jobq and crcb_back.
//
// Input channel: one message or codeword bit per beat on in_bit/in_last,
// taken on a clock edge with push high and full low. Result channel: the
// oldest result sits on out_bit/out_last/check_ok/poly_invalid while empty
// is low and is taken on an edge with pop high. Configuration: cfg_we,
// cfg_idx (0 low coefficients, 1 degree, 2 check mode) and cfg_wdata.
//
// The divider does one shift-and-XOR per accepted bit, so a new bit can
// be taken every cycle while full is low. A result passes through the job
// queue and the output register before it can be popped. An encode frame
// end yields 1 + degree results, one per cycle while the receiver pops;
// the two-entry job queue can then fill and full rise while the check
// bits go out. Check mode gives one result per frame, on the last bit.
//
// Reset clears the remainder, queue and output register and loads the
// CRC-16 generator x^16+x^12+x^5+1 in encode mode. When the receiver
// stops popping, the output register holds its beat, the queue fills
// and full backs up to the sender; nothing is dropped.
module crc_bit_serial_codec #(
	parameter int MAX_DEGREE = crcb_pkg::MAX_DEGREE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic        in_bit,
	input  logic        in_last,
	output logic        empty,
	input  logic        pop,
	output logic        out_bit,
	output logic        out_last,
	output logic        check_ok,
	output logic        poly_invalid
);
	import crcb_pkg::*;

	localparam int DW = $clog2(MAX_DEGREE + 1);

	logic                  wr_job;
	job_ctrl_t             wr_ctrl;
	logic [MAX_DEGREE-1:0] wr_rem;
	logic [DW-1:0]         wr_deg;
	logic                  rd_job;
	logic                  jq_empty;
	job_ctrl_t             rd_ctrl;
	logic [MAX_DEGREE-1:0] rd_rem;
	logic [DW-1:0]         rd_deg;

	crcb_front #(.MAX_DEGREE(MAX_DEGREE)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.in_bit    (in_bit),
		.in_last   (in_last),
		.q_full    (full),
		.q_push    (wr_job),
		.q_ctrl    (wr_ctrl),
		.q_rem     (wr_rem),
		.q_deg     (wr_deg)
	);

	crcb_jobq #(.MAX_DEGREE(MAX_DEGREE)) u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr_job),
		.wr_ctrl (wr_ctrl),
		.wr_rem  (wr_rem),
		.wr_deg  (wr_deg),
		.full    (full),
		.rd      (rd_job),
		.q_empty (jq_empty),
		.rd_ctrl (rd_ctrl),
		.rd_rem  (rd_rem),
		.rd_deg  (rd_deg)
	);

	crcb_back #(.MAX_DEGREE(MAX_DEGREE)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (jq_empty),
		.q_ctrl       (rd_ctrl),
		.q_rem        (rd_rem),
		.q_deg        (rd_deg),
		.q_pop        (rd_job),
		.empty        (empty),
		.pop          (pop),
		.out_bit      (out_bit),
		.out_last     (out_last),
		.check_ok     (check_ok),
		.poly_invalid (poly_invalid)
	);

endmodule
